### rtl/htfd_pkg.sv
// Shared types, codes and arithmetic helpers for the humidity/temperature frame decoder.
`default_nettype none

package htfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUMI_HI  = 3'd3;
    localparam logic [2:0] POS_HUMI_LO  = 3'd4;
    localparam logic [2:0] POS_HUMI_CRC = 3'd5;

    localparam logic [1:0] REG_TEMP_MIN = 2'd0;
    localparam logic [1:0] REG_TEMP_MAX = 2'd1;
    localparam logic [1:0] REG_HUMI_MIN = 2'd2;
    localparam logic [1:0] REG_HUMI_MAX = 2'd3;

    localparam logic signed [14:0] TEMP_MIN_RESET = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX_RESET = 15'sd12500;
    localparam logic [13:0]        HUMI_MIN_RESET = 14'd0;
    localparam logic [13:0]        HUMI_MAX_RESET = 14'd10000;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_CRC   = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic        crc_fail;
        logic [15:0] temp_word;
        logic [15:0] humi_word;
    } frame_t;

    typedef struct packed {
        logic signed [14:0] temp_min;
        logic signed [14:0] temp_max;
        logic [13:0]        humi_min;
        logic [13:0]        humi_max;
    } limits_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // m already carries the rounding offset; valid for m below 2^31
    function automatic logic [15:0] div_65535(input logic [31:0] m);
        logic [15:0] q1;
        logic [16:0] r;
        q1 = m[31:16];
        r  = {1'b0, m[15:0]} + {1'b0, q1};
        return q1 + 16'(r >= 17'd65535);
    endfunction

endpackage

`default_nettype wire

### rtl/htfd_front.sv
// Byte intake: frame position tracking, CRC check and word assembly.
`default_nettype none

module htfd_front
    import htfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   byte_valid,
    input  wire logic   byte_take,
    input  wire logic [7:0] data_byte,
    input  wire logic   frame_start,
    output frame_t      frame_out,
    output logic        frame_push
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        fail_reg, fail_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] humi_reg, humi_next;

    logic [2:0]  pos;
    logic [7:0]  crc_base;
    logic        fail_base;
    logic        accept;

    assign accept = byte_valid && byte_take;

    always_comb
    begin
        pos = (frame_start || pos_reg > POS_HUMI_CRC) ? POS_TEMP_HI : pos_reg;
        crc_base  = (pos == POS_TEMP_HI) ? CRC_INIT : crc_reg;
        fail_base = (pos == POS_TEMP_HI) ? 1'b0 : fail_reg;
        temp_next = temp_reg;
        humi_next = humi_reg;
        crc_next  = crc_base;
        fail_next = fail_base;
        unique case (pos)
            POS_TEMP_HI:
            begin
                temp_next = {data_byte, temp_reg[7:0]};
                crc_next  = crc8_update(crc_base, data_byte);
            end
            POS_TEMP_LO:
            begin
                temp_next = {temp_reg[15:8], data_byte};
                crc_next  = crc8_update(crc_base, data_byte);
            end
            POS_HUMI_HI:
            begin
                humi_next = {data_byte, humi_reg[7:0]};
                crc_next  = crc8_update(crc_base, data_byte);
            end
            POS_HUMI_LO:
            begin
                humi_next = {humi_reg[15:8], data_byte};
                crc_next  = crc8_update(crc_base, data_byte);
            end
            default:
            begin
                fail_next = fail_base || (data_byte != crc_base);
                crc_next  = CRC_INIT;
            end
        endcase
        pos_next = (pos == POS_HUMI_CRC) ? POS_TEMP_HI : pos + 3'd1;
    end

    assign frame_push = accept && (pos == POS_HUMI_CRC);
    assign frame_out  = '{crc_fail: fail_next, temp_word: temp_next, humi_word: humi_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_TEMP_HI;
            crc_reg  <= CRC_INIT;
            fail_reg <= 1'b0;
            temp_reg <= '0;
            humi_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            fail_reg <= fail_next;
            temp_reg <= temp_next;
            humi_reg <= humi_next;
        end
    end

endmodule

`default_nettype wire

### rtl/htfd_queue.sv
// Short frame queue between intake and conversion.
`default_nettype none

module htfd_queue
    import htfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  frame_t    push_data,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output frame_t    head
);

    frame_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/htfd_back.sv
// Conversion pipeline: scaling, range check, rounding and the result register.
`default_nettype none

module htfd_back
    import htfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  limits_t     limits,
    input  wire logic   head_valid,
    input  frame_t      head,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_take,
    output logic [46:0] out_data
);

    logic adv;

    // stage 1: scaled words and limit products
    logic                s1_valid_reg;
    logic                s1_fail_reg;
    logic [30:0]         s1_at_reg, s1_at_next;
    logic [29:0]         s1_ah_reg, s1_ah_next;
    logic [23:0]         s1_bt_reg, s1_bt_next;
    logic [22:0]         s1_bh_reg, s1_bh_next;
    logic signed [32:0]  s1_ltmin_reg, s1_ltmin_next;
    logic signed [32:0]  s1_ltmax_reg, s1_ltmax_next;
    logic [29:0]         s1_lhmin_reg, s1_lhmin_next;
    logic [29:0]         s1_lhmax_reg, s1_lhmax_next;
    logic signed [15:0]  xmin, xmax;

    // stage 2: range flag and rounding offsets
    logic                s2_valid_reg;
    logic                s2_fail_reg;
    logic                s2_range_reg, s2_range_next;
    logic [30:0]         s2_mt_reg;
    logic [29:0]         s2_mh_reg;
    logic [23:0]         s2_mbt_reg;
    logic [22:0]         s2_mbh_reg;

    // result register
    logic                out_valid_reg;
    logic [46:0]         out_data_reg, out_data_next;

    logic [15:0]         qt, qh, qbt, qbh;
    status_t             status;

    assign adv = !out_valid_reg || out_take;
    assign pop = adv && head_valid;

    always_comb
    begin
        s1_at_next = 31'(32'(head.temp_word) * 32'd17500);
        s1_ah_next = 30'(32'(head.humi_word) * 32'd10000);
        s1_bt_next = 24'(32'(head.temp_word) * 32'd175);
        s1_bh_next = 23'(32'(head.humi_word) * 32'd100);
        xmin = 16'(limits.temp_min) + 16'sd4500;
        xmax = 16'(limits.temp_max) + 16'sd4500;
        s1_ltmin_next = $signed({xmin[15], xmin, 16'h0000}) - $signed({{17{xmin[15]}}, xmin});
        s1_ltmax_next = $signed({xmax[15], xmax, 16'h0000}) - $signed({{17{xmax[15]}}, xmax});
        s1_lhmin_next = {limits.humi_min, 16'h0000} - {16'h0000, limits.humi_min};
        s1_lhmax_next = {limits.humi_max, 16'h0000} - {16'h0000, limits.humi_max};
    end

    assign s2_range_next = ($signed({2'b00, s1_at_reg}) < s1_ltmin_reg)
                        || ($signed({2'b00, s1_at_reg}) > s1_ltmax_reg)
                        || (s1_ah_reg < s1_lhmin_reg)
                        || (s1_ah_reg > s1_lhmax_reg);

    always_comb
    begin
        qt  = div_65535({1'b0, s2_mt_reg});
        qh  = div_65535({2'b00, s2_mh_reg});
        qbt = div_65535({8'h00, s2_mbt_reg});
        qbh = div_65535({9'h000, s2_mbh_reg});
        if (s2_fail_reg)
        begin
            status = STATUS_CRC;
        end
        else if (s2_range_reg)
        begin
            status = STATUS_RANGE;
        end
        else
        begin
            status = STATUS_OK;
        end
        out_data_next = '0;
        out_data_next[1:0] = status;
        if (status == STATUS_OK)
        begin
            out_data_next[16:2]  = 15'(qt - 16'd4500);
            out_data_next[30:17] = 14'(qh);
            out_data_next[39:31] = 9'(qbt - 16'd45);
            out_data_next[46:40] = 7'(qbh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fail_reg  <= head.crc_fail;
            s1_at_reg    <= s1_at_next;
            s1_ah_reg    <= s1_ah_next;
            s1_bt_reg    <= s1_bt_next;
            s1_bh_reg    <= s1_bh_next;
            s1_ltmin_reg <= s1_ltmin_next;
            s1_ltmax_reg <= s1_ltmax_next;
            s1_lhmin_reg <= s1_lhmin_next;
            s1_lhmax_reg <= s1_lhmax_next;
            s2_fail_reg  <= s1_fail_reg;
            s2_range_reg <= s2_range_next;
            s2_mt_reg    <= s1_at_reg + 31'd32767;
            s2_mh_reg    <= s1_ah_reg + 30'd32767;
            s2_mbt_reg   <= s1_bt_reg + 24'd32767;
            s2_mbh_reg   <= s1_bh_reg + 23'd32767;
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature frame decoder.
// Takes one frame byte per cycle on s_axis while s_axis_tready is high (tuser marks a frame
// start). After the sixth byte of a frame the decoded result leaves on m_axis through the
// conversion pipeline. s_axis_tready falls only when the four-entry frame queue between
// intake and conversion is full, which happens only under sustained back pressure on
// m_axis. Limit registers are written through cfg and always accepted.
`default_nettype none

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [1:0] status, [16:2] temperature_centi,
                                             // [30:17] humidity_centi,
                                             // [39:31] temperature_whole,
                                             // [46:40] humidity_whole, [47] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    limits_t     limits_reg, limits_next;
    frame_t      front_frame, q_head;
    logic        front_push, q_full, q_head_valid, q_pop;
    logic [46:0] out_data;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;

    always_comb
    begin
        limits_next = limits_reg;
        unique case (cfg_index)
            REG_TEMP_MIN: limits_next.temp_min = $signed(cfg_data);
            REG_TEMP_MAX: limits_next.temp_max = $signed(cfg_data);
            REG_HUMI_MIN: limits_next.humi_min = cfg_data[13:0];
            REG_HUMI_MAX: limits_next.humi_max = cfg_data[13:0];
            default:      limits_next = limits_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg <= '{temp_min: TEMP_MIN_RESET, temp_max: TEMP_MAX_RESET,
                            humi_min: HUMI_MIN_RESET, humi_max: HUMI_MAX_RESET};
        end
        else if (cfg_valid && cfg_ready)
        begin
            limits_reg <= limits_next;
        end
    end

    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (s_axis_tvalid),
        .byte_take   (s_axis_tready),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser[0]),
        .frame_out   (front_frame),
        .frame_push  (front_push)
    );

    htfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_data  (front_frame),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    htfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limits     (limits_reg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_take   (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data};

endmodule

`default_nettype wire

### rtl/htfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
`default_nettype none

module htfd_checker
    import htfd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_OK || m_axis_tdata[1:0] == STATUS_CRC
                           || m_axis_tdata[1:0] == STATUS_RANGE))
        else $error("invalid status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != STATUS_OK) |-> (m_axis_tdata[47:2] == '0))
        else $error("failed result carries nonzero values");

    a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == STATUS_OK)
            |-> ($signed(m_axis_tdata[16:2]) >= -15'sd4500
                 && $signed(m_axis_tdata[16:2]) <= 15'sd13000
                 && m_axis_tdata[30:17] <= 14'd10000))
        else $error("converted value outside sensor span");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result transfer changed");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

`default_nettype wire
